// ----- hw/rtl/chring_pkg.sv -----
// Shared types and constants for the consistent hash ring unit.
package chring_pkg;

    localparam int RING_ENTRIES    = 256;
    localparam int RING_AW         = $clog2(RING_ENTRIES);
    localparam int RING_CW         = RING_AW + 1;
    localparam int LABEL_MAX_BYTES = 255;

    localparam logic [31:0] HASH_SEED = 32'hbc9f1d34;
    localparam logic [31:0] HASH_MUL  = 32'hc6a4a793;

    localparam logic [1:0] KIND_KEY   = 2'd0;
    localparam logic [1:0] KIND_LABEL = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam logic RES_LOOKUP = 1'b0;
    localparam logic RES_INSERT = 1'b1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [15:0] string_length;
        logic        last;
        logic [7:0]  node_id;
    } in_t;

    typedef struct packed {
        logic [7:0]  node_id_res;
        logic [31:0] point;
        logic        result_kind;
        logic        ring_empty;
        logic        ring_full;
    } res_t;

    typedef struct packed {
        logic [31:0] point;
        logic [7:0]  node;
    } ring_entry_t;

endpackage

// ----- hw/rtl/chring_ram.sv -----
// Generic simple dual-port RAM with registered read.
module chring_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rd_data_reg <= mem_reg[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

// ----- hw/rtl/chring_mul.sv -----
// Shared hash multiplier: registered product of the operand and the hash constant.
module chring_mul (
    input  logic        clk,
    input  logic [31:0] operand,
    output logic [31:0] product
);

    logic [31:0] product_reg;

    always_ff @(posedge clk)
    begin
        product_reg <= operand * chring_pkg::HASH_MUL;
    end

    assign product = product_reg;

endmodule

// ----- hw/rtl/consistent_hash_ring_unit.sv -----
// Top level of the consistent hash ring unit: sequencer, hash state and ring control.
//
// Usage: one input word (kind, data_byte, string_length, last, node_id) is taken
// at a rising edge where start is high and busy is low. Strings come one byte per
// word. Kind 0 streams a key, kind 1 a label to insert, kind 2 clears the ring,
// kind 3 is dropped. A word with last set and kind 0 or 1 produces one result
// word, shown on result for exactly one cycle while result_valid is high; the
// receiver cannot stall it, so it must take it in that cycle.
//
// Steps per word (start to busy low):
//   non-final byte: a seed multiply on a string's first byte, then the byte step,
//   then a shared multiplier pass when the byte completes a 4-byte word.
//   final byte: the above, then the hash finish (plus a tail multiply with 1..3
//   bytes left over); a lookup then runs a binary search over the ring RAM (up to
//   9 steps for 256 entries) and a final read; an insert runs the same search,
//   moves each entry above the new slot up (up to 255), a read and a write each
//   on the single ring RAM port pair, then writes the new entry. Empty-ring
//   lookups and full-ring inserts end after the hash. Clear/unused kinds stay idle.
// All multiplies go through one registered 32x32 multiplier.
// Reset (rst_n low, asynchronous) empties the ring and drops any partial string.
// The ring RAM contents are not cleared; only entries below the count are read.
module consistent_hash_ring_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  chring_pkg::in_t  item,
    output logic             result_valid,
    output chring_pkg::res_t result
);

    localparam int AW = chring_pkg::RING_AW;
    localparam int CW = chring_pkg::RING_CW;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED,
        ST_BYTE,
        ST_WORD,
        ST_FIN,
        ST_TAIL,
        ST_RESOLVE,
        ST_SRCH,
        ST_SCMP,
        ST_LOOK,
        ST_SHRD,
        ST_SHWR
    } state_t;

    state_t                 state_reg, state_next;
    chring_pkg::in_t        item_reg, item_next;
    logic [15:0]            eff_reg, eff_next;
    logic [31:0]            acc_reg, acc_next;
    logic [23:0]            gather_reg, gather_next;
    logic [15:0]            pos_reg, pos_next;
    logic [31:0]            key_reg, key_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          lo_reg, lo_next;
    logic [CW-1:0]          hi_reg, hi_next;
    logic [AW-1:0]          mid_reg, mid_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic                   res_valid_reg, res_valid_next;
    chring_pkg::res_t       res_reg, res_next;

    logic [31:0]            mul_op;
    logic [31:0]            mul_p;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [AW-1:0]          ram_raddr;
    chring_pkg::ring_entry_t ram_wdata;
    chring_pkg::ring_entry_t ram_rdata;

    logic [15:0]            in_eff;
    logic [CW:0]            lo_hi_sum;
    logic [1:0]             lane;
    logic [31:0]            full_word;

    chring_mul u_mul (
        .clk     (clk),
        .operand (mul_op),
        .product (mul_p)
    );

    chring_ram #(
        .WIDTH ($bits(chring_pkg::ring_entry_t)),
        .DEPTH (chring_pkg::RING_ENTRIES)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Effective length: labels are clipped to the label limit
    always_comb
    begin
        in_eff = item.string_length;
        if (item.kind == chring_pkg::KIND_LABEL &&
            item.string_length > 16'(chring_pkg::LABEL_MAX_BYTES))
        begin
            in_eff = 16'(chring_pkg::LABEL_MAX_BYTES);
        end
    end

    assign lo_hi_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign lane      = pos_reg[1:0];
    assign full_word = {item_reg.data_byte, gather_reg};

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        eff_next       = eff_reg;
        acc_next       = acc_reg;
        gather_next    = gather_reg;
        pos_next       = pos_reg;
        key_next       = key_reg;
        count_next     = count_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        idx_next       = idx_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        mul_op         = 32'd0;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg[AW-1:0];
        ram_wdata      = '{point: key_reg, node: item_reg.node_id};
        ram_raddr      = mid_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    item_next = item;
                    eff_next  = in_eff;
                    case (item.kind) inside
                        chring_pkg::KIND_KEY, chring_pkg::KIND_LABEL:
                        begin
                            if (pos_reg == 16'd0)
                            begin
                                // seed = HASH_SEED ^ (len * HASH_MUL)
                                mul_op      = {16'd0, in_eff};
                                gather_next = 24'd0;
                                state_next  = ST_SEED;
                            end
                            else
                            begin
                                state_next = ST_BYTE;
                            end
                        end
                        chring_pkg::KIND_CLEAR:
                        begin
                            count_next  = '0;
                            pos_next    = 16'd0;
                            acc_next    = 32'd0;
                            gather_next = 24'd0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_SEED:
            begin
                acc_next   = chring_pkg::HASH_SEED ^ mul_p;
                state_next = ST_BYTE;
            end

            ST_BYTE:
            begin
                state_next = item_reg.last ? ST_FIN : ST_IDLE;
                if (pos_reg < eff_reg)
                begin
                    pos_next = pos_reg + 16'd1;
                    if (lane == 2'd3)
                    begin
                        mul_op      = acc_reg + full_word;
                        gather_next = 24'd0;
                        state_next  = ST_WORD;
                    end
                    else
                    begin
                        gather_next = gather_reg |
                            (24'(item_reg.data_byte) << {lane, 3'b000});
                    end
                end
            end

            ST_WORD:
            begin
                acc_next   = mul_p ^ (mul_p >> 16);
                state_next = item_reg.last ? ST_FIN : ST_IDLE;
            end

            ST_FIN:
            begin
                if (lane != 2'd0)
                begin
                    mul_op     = acc_reg + {8'd0, gather_reg};
                    state_next = ST_TAIL;
                end
                else
                begin
                    key_next   = acc_reg;
                    state_next = ST_RESOLVE;
                end
            end

            ST_TAIL:
            begin
                key_next   = mul_p ^ (mul_p >> 24);
                state_next = ST_RESOLVE;
            end

            ST_RESOLVE:
            begin
                pos_next    = 16'd0;
                acc_next    = 32'd0;
                gather_next = 24'd0;
                lo_next     = '0;
                hi_next     = count_reg;
                res_next.point       = key_reg;
                res_next.ring_empty  = 1'b0;
                res_next.ring_full   = 1'b0;
                if (item_reg.kind == chring_pkg::KIND_KEY)
                begin
                    res_next.result_kind = chring_pkg::RES_LOOKUP;
                    res_next.node_id_res = 8'd0;
                    if (count_reg == '0)
                    begin
                        res_next.ring_empty = 1'b1;
                        res_valid_next      = 1'b1;
                        state_next          = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_SRCH;
                    end
                end
                else
                begin
                    res_next.result_kind = chring_pkg::RES_INSERT;
                    res_next.node_id_res = item_reg.node_id;
                    if (count_reg >= CW'(chring_pkg::RING_ENTRIES))
                    begin
                        res_next.ring_full = 1'b1;
                        res_valid_next     = 1'b1;
                        state_next         = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_SRCH;
                    end
                end
            end

            // binary search for the first point strictly above the key
            ST_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = lo_hi_sum[AW:1];
                    ram_raddr  = lo_hi_sum[AW:1];
                    state_next = ST_SCMP;
                end
                else if (item_reg.kind == chring_pkg::KIND_KEY)
                begin
                    // past the end wraps to entry 0
                    ram_raddr  = (lo_reg >= count_reg) ? '0 : lo_reg[AW-1:0];
                    state_next = ST_LOOK;
                end
                else
                begin
                    idx_next   = count_reg;
                    state_next = ST_SHRD;
                end
            end

            ST_SCMP:
            begin
                if (ram_rdata.point > key_reg)
                begin
                    hi_next = {1'b0, mid_reg};
                end
                else
                begin
                    lo_next = {1'b0, mid_reg} + CW'(1);
                end
                state_next = ST_SRCH;
            end

            ST_LOOK:
            begin
                res_next.node_id_res = ram_rdata.node;
                res_valid_next       = 1'b1;
                state_next           = ST_IDLE;
            end

            // move entries up one slot, top down, then drop the new one in
            ST_SHRD:
            begin
                if (idx_reg > lo_reg)
                begin
                    ram_raddr  = idx_reg[AW-1:0] - AW'(1);
                    state_next = ST_SHWR;
                end
                else
                begin
                    ram_we         = 1'b1;
                    ram_waddr      = lo_reg[AW-1:0];
                    count_next     = count_reg + CW'(1);
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            ST_SHWR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg[AW-1:0];
                ram_wdata  = ram_rdata;
                idx_next   = idx_reg - CW'(1);
                state_next = ST_SHRD;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            item_reg      <= '0;
            eff_reg       <= 16'd0;
            acc_reg       <= 32'd0;
            gather_reg    <= 24'd0;
            pos_reg       <= 16'd0;
            key_reg       <= 32'd0;
            count_reg     <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            mid_reg       <= '0;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            item_reg      <= item_next;
            eff_reg       <= eff_next;
            acc_reg       <= acc_next;
            gather_reg    <= gather_next;
            pos_reg       <= pos_next;
            key_reg       <= key_next;
            count_reg     <= count_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            mid_reg       <= mid_next;
            idx_reg       <= idx_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule
